// ===== sv/multi_tap_ring_delay_defines.svh =====
// Assertion macros used by the delay line sequencer (mtrd_seq).
`ifndef MULTI_TAP_RING_DELAY_DEFINES_SVH
`define MULTI_TAP_RING_DELAY_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MTRD_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
`define MTRD_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define MTRD_ASSERT_IMP(label, clk, rst_n, cond, prop, msg)
`define MTRD_ASSERT_NXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

// ===== sv/mtrd_pkg.sv =====
package mtrd_pkg;

    localparam int DEPTH     = 65536;
    localparam int TAPS      = 8;
    localparam int TAP_SLOTS = 8;
    localparam int SAMPLE_W  = 16;
    localparam int DELAY_W   = 17;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CALC_W    = (DELAY_W > ADDR_W + 1) ? DELAY_W : ADDR_W + 1;
    localparam int CFG_IDX_W = 4;
    localparam int TAP_IDX_W = $clog2(TAP_SLOTS);
    localparam int CNT_W     = TAP_IDX_W + 1;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [DELAY_W-1:0]  delay_t;
    typedef logic [ADDR_W-1:0]   addr_t;

    typedef struct packed {
        delay_t [TAP_SLOTS-1:0]  delay;
        logic   [TAP_SLOTS-1:0]  enable;
    } tap_cfg_t;

    typedef struct packed {
        sample_t [TAP_SLOTS-1:0] tap;
        logic    [TAP_SLOTS-1:0] valid;
    } result_t;

endpackage

// ===== sv/multi_tap_ring_delay.sv =====
// Eight-tap circular audio delay line.
// Input channel (in_valid/in_ready): one sample a transfer; with sample_present
// low a zero is stored instead of sample_in. Each sample is written at the head
// of a 65536-entry memory, then every enabled tap reads the entry lying
// (tapN_delay - 1) samples back from that newest sample.
// Output channel (out_valid/out_ready): one result per input sample, holding
// all eight tap values and the tap_valid mask; disabled taps give zero.
// Configuration: cfg_we with cfg_index 0..7 writes tapN_delay (0 disables the
// tap); other indexes are ignored. Write only while no sample is in flight.
// Samples are processed one at a time, each in steps: a write step, eight tap
// reads through the single read port of the memory plus a step for the last
// read data, and a hand-over to the output register. A second sample is
// buffered while the first is worked on, and a finished result waits in its
// output register while the next sample proceeds up to its hand-over step.
// Reset clears the taps, the head and the fill tracking; memory entries never
// written since reset read as zero without any clearing pass. While out_ready
// is low the result is held and input stalls once the buffer is full.
module multi_tap_ring_delay
    import mtrd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DELAY_W-1:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   sample_in,
    input  logic                 sample_present,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [15:0]   tap0_out,
    output logic signed [15:0]   tap1_out,
    output logic signed [15:0]   tap2_out,
    output logic signed [15:0]   tap3_out,
    output logic signed [15:0]   tap4_out,
    output logic signed [15:0]   tap5_out,
    output logic signed [15:0]   tap6_out,
    output logic signed [15:0]   tap7_out,
    output logic [7:0]           tap_valid
);

    logic     buf_valid_reg;
    sample_t  buf_sample_reg;
    logic     item_take;
    tap_cfg_t tap_cfg;
    result_t  result;

    assign in_ready = !buf_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg  <= 1'b0;
            buf_sample_reg <= '0;
        end
        else if (in_valid && !buf_valid_reg)
        begin
            buf_valid_reg  <= 1'b1;
            buf_sample_reg <= sample_present ? sample_t'(sample_in) : '0;
        end
        else if (item_take)
        begin
            buf_valid_reg <= 1'b0;
        end
    end

    mtrd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tap_cfg   (tap_cfg)
    );

    mtrd_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (buf_valid_reg),
        .item_sample (buf_sample_reg),
        .item_take   (item_take),
        .tap_cfg     (tap_cfg),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .result      (result)
    );

    assign tap0_out  = result.tap[0];
    assign tap1_out  = result.tap[1];
    assign tap2_out  = result.tap[2];
    assign tap3_out  = result.tap[3];
    assign tap4_out  = result.tap[4];
    assign tap5_out  = result.tap[5];
    assign tap6_out  = result.tap[6];
    assign tap7_out  = result.tap[7];
    assign tap_valid = result.valid;

endmodule

// ===== sv/mtrd_ram.sv =====
module mtrd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mtrd_cfg.sv =====
module mtrd_cfg
    import mtrd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DELAY_W-1:0]   cfg_data,
    output tap_cfg_t             tap_cfg
);

    delay_t delay_reg [TAP_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAP_SLOTS; i++)
            begin
                delay_reg[i] <= '0;
            end
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(TAP_SLOTS)))
        begin
            delay_reg[cfg_index[TAP_IDX_W-1:0]] <= cfg_data;
        end
    end

    // Slots at or above TAPS stay disabled even when their register is written.
    always_comb
    begin
        for (int t = 0; t < TAP_SLOTS; t++)
        begin
            tap_cfg.delay[t]  = delay_reg[t];
            tap_cfg.enable[t] = (t < TAPS) && (|delay_reg[t]);
        end
    end

endmodule

// ===== sv/mtrd_seq.sv =====
`include "multi_tap_ring_delay_defines.svh"

module mtrd_seq
    import mtrd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  sample_t  item_sample,
    output logic     item_take,
    input  tap_cfg_t tap_cfg,
    input  logic     out_ready,
    output logic     out_valid,
    output result_t  result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_FINISH
    } state_t;

    state_t                         state_reg;
    addr_t                          head_reg;
    logic                           wrapped_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [TAP_IDX_W-1:0]           rd_tap_reg;
    logic                           rd_hit_reg;
    logic                           rd_busy_reg;
    sample_t [TAP_SLOTS-1:0]        work_reg;
    logic                           out_valid_reg;
    result_t                        out_reg;

    logic                 head_wrap;
    addr_t                head_inc;
    logic [TAP_IDX_W-1:0] tap;
    logic [CALC_W-1:0]    len;
    logic [CALC_W-1:0]    len_c;
    logic [CALC_W-1:0]    head_w;
    logic [CALC_W-1:0]    pos_w;
    addr_t                pos;
    logic                 hit;
    logic                 rd_issue;
    sample_t              rdata;

    assign item_take = (state_reg == S_IDLE) && item_valid;
    assign head_wrap = (head_reg == ADDR_W'(DEPTH - 1));
    assign head_inc  = head_wrap ? '0 : head_reg + 1'b1;

    // Tap address: head minus the clamped length, modulo the depth. Entries
    // not yet reached by the head since reset read as zero.
    always_comb
    begin
        tap    = cnt_reg[TAP_IDX_W-1:0];
        len    = CALC_W'(tap_cfg.delay[tap]);
        len_c  = (len > CALC_W'(DEPTH)) ? CALC_W'(DEPTH) : len;
        head_w = CALC_W'(head_reg);
        if (len_c <= head_w)
        begin
            pos_w = head_w - len_c;
        end
        else
        begin
            pos_w = head_w + CALC_W'(DEPTH) - len_c;
        end
        pos      = pos_w[ADDR_W-1:0];
        hit      = tap_cfg.enable[tap] && (wrapped_reg || (pos < head_reg));
        rd_issue = (state_reg == S_READ) && (cnt_reg < CNT_W'(TAP_SLOTS));
    end

    mtrd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (item_take),
        .waddr (head_reg),
        .wdata (item_sample),
        .re    (rd_issue),
        .raddr (pos),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            wrapped_reg   <= 1'b0;
            cnt_reg       <= '0;
            rd_tap_reg    <= '0;
            rd_hit_reg    <= 1'b0;
            rd_busy_reg   <= 1'b0;
            work_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            // In the finish step the hand-over below decides the flag itself.
            if (out_valid_reg && out_ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        head_reg <= head_inc;
                        if (head_wrap)
                        begin
                            wrapped_reg <= 1'b1;
                        end
                        cnt_reg   <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    cnt_reg     <= cnt_reg + 1'b1;
                    rd_busy_reg <= rd_issue;
                    rd_tap_reg  <= tap;
                    rd_hit_reg  <= hit;
                    if (rd_busy_reg)
                    begin
                        work_reg[rd_tap_reg] <= rd_hit_reg ? rdata : '0;
                    end
                    if (!rd_issue)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg.tap   <= work_reg;
                        out_reg.valid <= tap_cfg.enable;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

    `MTRD_ASSERT_NXT(a_head_advances, clk, rst_n, item_take, head_reg != $past(head_reg), "head did not advance on a new sample")
    `MTRD_ASSERT_NXT(a_read_ends, clk, rst_n, (state_reg == S_READ) && !rd_issue, state_reg == S_FINISH, "tap read sweep did not end")
    `MTRD_ASSERT_NXT(a_finish_waits, clk, rst_n, (state_reg == S_FINISH) && out_valid_reg && !out_ready, (state_reg == S_FINISH) && out_valid_reg, "result overwritten while held")
    `MTRD_ASSERT_IMP(a_load_from_finish, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == S_FINISH, "result raised outside the finish step")

endmodule
